@@ src/uid_pkg.sv @@
package uid_pkg;

    localparam int SLOTS    = 16;
    localparam int ID_BYTES = 8;

    localparam int KEY_W  = 64;
    localparam int LEN_W  = 4;
    localparam int OP_W   = 2;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = SLOT_W + 1;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL   = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [KEY_W-1:0] key;
    } t_slot;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_slot             data;
    } t_wr_req;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } t_rd_req;

    // keeps the low len bytes of a key
    function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < KEY_W / 8; b++) begin
            if (LEN_W'(b) < len) begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

@@ src/uid_if.sv @@
interface uid_req_if;
    logic                       valid;
    logic                       ready;
    logic [uid_pkg::OP_W-1:0]   opcode;
    logic [uid_pkg::KEY_W-1:0]  key_bytes;
    logic [uid_pkg::LEN_W-1:0]  key_length;

    modport source (output valid, opcode, key_bytes, key_length, input ready);
    modport sink   (input valid, opcode, key_bytes, key_length, output ready);
endinterface

interface uid_rsp_if;
    logic valid;
    logic ready;
    logic ok;

    modport source (output valid, ok, input ready);
    modport sink   (input valid, ok, output ready);
endinterface

@@ src/uid_slot_ram.sv @@
module uid_slot_ram (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  uid_pkg::t_wr_req i_wr,
    input  uid_pkg::t_rd_req i_rd,
    output uid_pkg::t_slot   o_rd_data
);

    uid_pkg::t_slot r_mem [uid_pkg::SLOTS];
    logic [uid_pkg::SLOTS-1:0] r_vld;
    uid_pkg::t_slot r_rd_data;
    logic           r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
            r_rd_vld  <= r_vld[i_rd.addr];
        end
    end

    // never-written slots read as free
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

@@ src/user_id_table.sv @@
// channel  | dir | payload                              | handshake
// i_req    | in  | opcode, key_bytes[63:0], key_length  | valid/ready
// o_rsp    | out | ok                                   | valid/ready
//
// One request at a time: accept, then a scan of one slot per cycle through the
// slot RAM (registered read), stopping at the first hit; a bad length or unused
// opcode is refused without a scan.
// Add/delete write back into the slot being compared, so no forwarding is needed.
// Reset (synchronous, i_rst_n low) clears the per-slot valid flags: all slots free.
// A stalled response holds in the output register; the next request is accepted
// meanwhile and waits at the end of its scan until the register frees up.
module user_id_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    uid_req_if.sink     i_req,
    uid_rsp_if.source   o_rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state                        r_state;
    logic [uid_pkg::OP_W-1:0]      r_op;
    logic [uid_pkg::LEN_W-1:0]     r_len;
    logic [uid_pkg::KEY_W-1:0]     r_key;
    logic [uid_pkg::CNT_W-1:0]     r_rd_cnt;
    logic                          r_cmp_vld;
    logic [uid_pkg::SLOT_W-1:0]    r_cmp_idx;
    logic                          r_ok;
    logic                          r_out_valid;
    logic                          r_out_ok;

    uid_pkg::t_slot   rd_data;
    uid_pkg::t_rd_req rd_req;
    uid_pkg::t_wr_req wr_req;
    logic             slot_free;
    logic             slot_match;
    logic             hit;
    logic             do_wr;
    logic             eval;
    logic             last;
    logic             len_ok;
    logic             op_ok;

    uid_slot_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr_req),
        .i_rd      (rd_req),
        .o_rd_data (rd_data)
    );

    always_comb begin
        slot_free  = (rd_data.len == '0);
        slot_match = (rd_data.len == r_len) && (rd_data.key == r_key);
        case (r_op)
            uid_pkg::OP_ADD: begin
                hit   = slot_free || slot_match;
                do_wr = slot_free;
            end
            uid_pkg::OP_DEL: begin
                hit   = slot_match;
                do_wr = slot_match;
            end
            default: begin
                hit   = slot_match;
                do_wr = 1'b0;
            end
        endcase

        eval = (r_state == ST_SCAN) && r_cmp_vld;
        last = (r_cmp_idx == uid_pkg::SLOT_W'(uid_pkg::SLOTS - 1));

        rd_req.en   = (r_state == ST_SCAN) && (r_rd_cnt < uid_pkg::CNT_W'(uid_pkg::SLOTS));
        rd_req.addr = r_rd_cnt[uid_pkg::SLOT_W-1:0];

        wr_req.en       = eval && do_wr;
        wr_req.addr     = r_cmp_idx;
        wr_req.data.len = (r_op == uid_pkg::OP_ADD) ? r_len : '0;
        wr_req.data.key = (r_op == uid_pkg::OP_ADD) ? r_key : '0;

        len_ok = (i_req.key_length != '0)
              && (i_req.key_length <= uid_pkg::LEN_W'(uid_pkg::ID_BYTES));
        op_ok  = (i_req.opcode == uid_pkg::OP_ADD) || (i_req.opcode == uid_pkg::OP_DEL)
              || (i_req.opcode == uid_pkg::OP_CHECK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_op      <= i_req.opcode;
                        r_len     <= i_req.key_length;
                        r_key     <= i_req.key_bytes & uid_pkg::key_mask(i_req.key_length);
                        r_rd_cnt  <= '0;
                        r_cmp_vld <= 1'b0;
                        r_ok      <= 1'b0;
                        r_state   <= (len_ok && op_ok) ? ST_SCAN : ST_DONE;
                    end
                end
                ST_SCAN: begin
                    r_cmp_vld <= rd_req.en && !(eval && (hit || last));
                    r_cmp_idx <= rd_req.addr;
                    if (rd_req.en) begin
                        r_rd_cnt <= r_rd_cnt + uid_pkg::CNT_W'(1);
                    end
                    if (eval && (hit || last)) begin
                        r_ok      <= hit;
                        r_state   <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_ok    <= r_ok;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.ok    = r_out_ok;

endmodule

@@ test/user_id_table_tb.sv @@
module user_id_table_tb;

    // opcode value the block must reject
    localparam logic [uid_pkg::OP_W-1:0] OP_RSVD = 2'd3;

    localparam int N_RANDOM  = 1225;
    localparam int POOL_SIZE = 32;
    localparam int PHASE_LEN = 150;
    localparam int HOLD_AT   = 500;
    localparam int HOLD_LEN  = 300;
    localparam int TAIL_WAIT = 2 * uid_pkg::SLOTS + 10;
    localparam int LIMIT     = 1000000;

    typedef struct packed {
        logic [uid_pkg::OP_W-1:0]  op;
        logic [uid_pkg::KEY_W-1:0] key;
        logic [uid_pkg::LEN_W-1:0] len;
        logic                      drain;   // sender waits for every response before offering
    } t_uid_req;

    logic i_clk;
    logic i_rst_n;

    uid_req_if req_if();
    uid_rsp_if rsp_if();

    user_id_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow copy of the slot table
    logic [uid_pkg::KEY_W-1:0] tbl_key [uid_pkg::SLOTS];
    logic [uid_pkg::LEN_W-1:0] tbl_len [uid_pkg::SLOTS];

    // identifiers the random part draws from
    logic [uid_pkg::KEY_W-1:0] pool_key [POOL_SIZE];
    logic [uid_pkg::LEN_W-1:0] pool_len [POOL_SIZE];

    t_uid_req pending_q [$];
    bit       ok_q [$];
    t_uid_req cur_req;

    int n_items   = 0;
    int sent_cnt  = 0;
    int rcv_cnt   = 0;
    int err_cnt   = 0;
    int drv_gap   = 0;
    int rsp_gap   = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    int n_stored = 0, n_present = 0, n_full = 0, n_deleted = 0;
    int n_found = 0, n_missing = 0, n_rejected = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [uid_pkg::KEY_W-1:0] low_bytes(
            input logic [uid_pkg::LEN_W-1:0] n);
        if (n >= uid_pkg::ID_BYTES) return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // applies one request to the shadow table, returns the expected ok
    function automatic bit lookup_and_update(input t_uid_req r);
        logic [uid_pkg::KEY_W-1:0] k;
        bit ok;
        bit done;
        bit hit;
        ok = 1'b0;
        done = 1'b0;
        if (r.len == 0 || r.len > uid_pkg::ID_BYTES) begin
            n_rejected++;
            return 1'b0;
        end
        k = r.key & low_bytes(r.len);
        for (int s = 0; s < uid_pkg::SLOTS && !done; s++) begin
            hit = (tbl_len[s] == r.len) && (tbl_key[s] == k);
            case (r.op)
                uid_pkg::OP_ADD: begin
                    // first free slot or first match, whichever comes first
                    if (tbl_len[s] == 0) begin
                        tbl_key[s] = k;
                        tbl_len[s] = r.len;
                        ok = 1'b1;
                        done = 1'b1;
                        n_stored++;
                    end else if (hit) begin
                        ok = 1'b1;
                        done = 1'b1;
                        n_present++;
                    end
                end
                uid_pkg::OP_DEL: begin
                    if (hit) begin
                        tbl_key[s] = '0;
                        tbl_len[s] = '0;
                        ok = 1'b1;
                        done = 1'b1;
                        n_deleted++;
                    end
                end
                uid_pkg::OP_CHECK: begin
                    if (hit) begin
                        ok = 1'b1;
                        done = 1'b1;
                        n_found++;
                    end
                end
                default: done = 1'b1;
            endcase
        end
        if (!ok) begin
            case (r.op)
                uid_pkg::OP_ADD:                   n_full++;
                uid_pkg::OP_DEL, uid_pkg::OP_CHECK: n_missing++;
                default:                           n_rejected++;
            endcase
        end
        return ok;
    endfunction

    function automatic void queue_request(input logic [uid_pkg::OP_W-1:0] op,
                                          input logic [uid_pkg::KEY_W-1:0] key,
                                          input logic [uid_pkg::LEN_W-1:0] len,
                                          input bit drain);
        t_uid_req r;
        r.op = op;
        r.key = key;
        r.len = len;
        r.drain = drain;
        pending_q.push_back(r);
        n_items++;
    endfunction

    // phases lean toward filling, mixing and emptying the table in turn
    function automatic void queue_random(input int idx);
        int p;
        int w;
        int phase;
        logic [uid_pkg::OP_W-1:0] op;
        phase = (idx / PHASE_LEN) % 3;
        if ($urandom_range(99) < 8) begin
            queue_request(uid_pkg::OP_W'($urandom), {$urandom, $urandom},
                          uid_pkg::LEN_W'($urandom), 1'b0);
            return;
        end
        p = $urandom_range(POOL_SIZE - 1);
        w = $urandom_range(99);
        case (phase)
            0: op = (w < 70) ? uid_pkg::OP_ADD : (w < 85) ? uid_pkg::OP_CHECK : uid_pkg::OP_DEL;
            1: op = (w < 40) ? uid_pkg::OP_ADD : (w < 70) ? uid_pkg::OP_CHECK : uid_pkg::OP_DEL;
            default:
               op = (w < 20) ? uid_pkg::OP_ADD : (w < 45) ? uid_pkg::OP_CHECK : uid_pkg::OP_DEL;
        endcase
        // junk above the valid bytes must not matter
        queue_request(op,
                      pool_key[p] | ({$urandom, $urandom} & ~low_bytes(pool_len[p])),
                      pool_len[p], (idx % PHASE_LEN) == 0);
    endfunction

    task automatic report_mismatch(input string what, input bit want, input logic got);
        $display("MISMATCH response %0d: %s (expected ok=%0b, got %b)",
                 rcv_cnt, what, want, got);
        err_cnt++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                ok_q.push_back(lookup_and_update(cur_req));
                sent_cnt++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    req_if.valid <= 1'b0;
                end else if (pending_q.size() > 0 &&
                             (!pending_q[0].drain || sent_cnt == rcv_cnt)) begin
                    cur_req = pending_q.pop_front();
                    req_if.valid      <= 1'b1;
                    req_if.opcode     <= cur_req.op;
                    req_if.key_bytes  <= cur_req.key;
                    req_if.key_length <= cur_req.len;
                    drv_gap = ((sent_cnt / 200) % 4 == 3) ? 0 : pick_gap();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response ready: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else if (!hold_done && rcv_cnt >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            rsp_if.ready <= 1'b0;
        end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
            if ((rcv_cnt / 200) % 4 != 1 && $urandom_range(3) == 0) rsp_gap = pick_gap();
        end
    end

    // response checker
    always @(posedge i_clk) begin : chk
        bit want_ok;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (ok_q.size() == 0) begin
                report_mismatch("response with no request outstanding", 1'b0, rsp_if.ok);
            end else begin
                want_ok = ok_q.pop_front();
                if (rsp_if.ok !== want_ok) report_mismatch("ok differs", want_ok, rsp_if.ok);
            end
            rcv_cnt <= rcv_cnt + 1;
        end
    end

    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("timeout: %0d of %0d requests sent, %0d responses", sent_cnt, n_items, rcv_cnt);
        $display("user_id_table verification failed");
        $finish;
    end

    initial begin
        int base;
        logic [uid_pkg::LEN_W-1:0] l;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.opcode     = '0;
        req_if.key_bytes  = '0;
        req_if.key_length = '0;
        rsp_if.ready      = 1'b0;
        for (int s = 0; s < uid_pkg::SLOTS; s++) begin
            tbl_key[s] = '0;
            tbl_len[s] = '0;
        end

        // independent ids, one-bit neighbors, and same bytes at another length
        for (int p = 0; p < 16; p++) begin
            pool_len[p] = uid_pkg::LEN_W'(1 + p % 8);
            pool_key[p] = {$urandom, $urandom} & low_bytes(pool_len[p]);
        end
        for (int p = 16; p < 24; p++) begin
            pool_len[p] = pool_len[p - 16];
            pool_key[p] = pool_key[p - 16] ^ (64'd1 << $urandom_range(8 * pool_len[p] - 1));
        end
        for (int p = 24; p < POOL_SIZE; p++) begin
            base = p - 24;
            l = uid_pkg::LEN_W'(pool_len[base] % 8 + 1);
            pool_len[p] = l;
            pool_key[p] = (pool_key[base] | ({$urandom, $urandom} & ~low_bytes(pool_len[base])))
                          & low_bytes(l);
        end

        // directed: extremes, length mismatch, duplicate stored ahead of a copy
        queue_request(uid_pkg::OP_CHECK, '1, 4'd1, 1'b0);
        queue_request(uid_pkg::OP_ADD,   '1, 4'd1, 1'b0);
        queue_request(uid_pkg::OP_ADD,   '1, 4'd8, 1'b0);
        queue_request(uid_pkg::OP_ADD,   '0, 4'd8, 1'b0);
        queue_request(uid_pkg::OP_CHECK, '1, 4'd1, 1'b0);
        queue_request(uid_pkg::OP_CHECK, '1, 4'd2, 1'b0);
        queue_request(uid_pkg::OP_CHECK, '1, 4'd8, 1'b0);
        queue_request(uid_pkg::OP_ADD,   '1, 4'd1, 1'b0);
        queue_request(uid_pkg::OP_DEL,   '1, 4'd1, 1'b0);
        queue_request(uid_pkg::OP_ADD,   '1, 4'd8, 1'b0);
        queue_request(uid_pkg::OP_DEL,   '1, 4'd8, 1'b0);
        queue_request(uid_pkg::OP_CHECK, '1, 4'd8, 1'b0);
        queue_request(uid_pkg::OP_DEL,   '1, 4'd8, 1'b0);
        queue_request(uid_pkg::OP_DEL,   '1, 4'd8, 1'b0);
        queue_request(uid_pkg::OP_ADD,   '1, 4'd0, 1'b0);
        queue_request(uid_pkg::OP_ADD,   '1, 4'd9, 1'b0);
        queue_request(uid_pkg::OP_CHECK, '0, 4'd15, 1'b0);
        queue_request(uid_pkg::OP_DEL,   '0, 4'd0, 1'b0);
        queue_request(OP_RSVD,           '1, 4'd4, 1'b0);
        queue_request(uid_pkg::OP_CHECK, '0, 4'd8, 1'b0);
        queue_request(uid_pkg::OP_ADD,   64'h0123_4567_89AB_CDEF, 4'd4, 1'b0);
        queue_request(uid_pkg::OP_CHECK, 64'hFEDC_BA98_89AB_CDEF, 4'd4, 1'b0);
        queue_request(uid_pkg::OP_DEL,   '0, 4'd8, 1'b0);
        queue_request(uid_pkg::OP_CHECK, '0, 4'd1, 1'b0);

        for (int i = 0; i < N_RANDOM; i++) queue_random(i);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (rcv_cnt == n_items);
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("%0d requests: %0d stored, %0d already present, %0d refused on a full table",
                 n_items, n_stored, n_present, n_full);
        $display("%0d deleted, %0d found, %0d not present, %0d bad length or opcode",
                 n_deleted, n_found, n_missing, n_rejected);
        if (err_cnt == 0 && ok_q.size() == 0) begin
            $display("user_id_table verification clean");
        end else begin
            $display("user_id_table verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/uid_pkg.sv
src/uid_if.sv
src/uid_slot_ram.sv
src/user_id_table.sv
test/user_id_table_tb.sv
